[rtl/mibm_pkg.sv]
// Shared constants and types for the lowest-id bearing median filter.
package mibm_pkg;

   // History length and derived widths
   localparam int HISTORY_DEPTH = 20;
   localparam int AGE_W         = $clog2(HISTORY_DEPTH);
   localparam int MID_HI        = HISTORY_DEPTH / 2;
   localparam int MID_LO        = HISTORY_DEPTH / 2 - 1;

   // Field widths
   localparam int ID_W      = 16;
   localparam int BEARING_W = 9;

   // Fixed codes
   localparam logic [ID_W-1:0]      START_ID   = ID_W'(10000);
   localparam logic [BEARING_W-1:0] EMPTY_CODE = BEARING_W'(255);
   localparam logic                 OP_SOURCE  = 1'b0;
   localparam logic                 OP_EMPTY   = 1'b1;

   // One history sample held in a cell: value plus age in frames
   typedef struct packed {
      logic signed [BEARING_W-1:0] value;
      logic [AGE_W-1:0]            age;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_MEDIAN
   } state_type;

endpackage

[rtl/mibm_if.sv]
// Valid/ready channel interfaces for source entries and median results.
interface mibm_req_if;
   import mibm_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [ID_W-1:0]             source_id;
   logic signed [BEARING_W-1:0] bearing;
   logic                        last_in_frame;

   modport source (output valid, op, source_id, bearing, last_in_frame, input ready);
   modport sink   (input valid, op, source_id, bearing, last_in_frame, output ready);
endinterface

interface mibm_rsp_if;
   import mibm_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [BEARING_W-1:0] smoothed_bearing;

   modport source (output valid, smoothed_bearing, input ready);
   modport sink   (input valid, smoothed_bearing, output ready);
endinterface

[rtl/mibm_cell.sv]
// One cell of the sorted history chain: holds a sample and its age.
module mibm_cell
   import mibm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic signed [BEARING_W-1:0] new_value,
   input  entry_type                   prv_entry,
   input  entry_type                   nxt_entry,
   input  logic                        prv_exists,
   input  logic                        nxt_exists,
   input  logic                        clear_in,
   input  logic [AGE_W-1:0]            reset_age,
   output logic                        clear_out,
   output entry_type                   entry
);

   entry_type entry_ff, entry_in;
   logic      is_oldest;

   entry_type                   li, lp;
   logic                        li_inf, lp_ninf, li_le, lp_le;
   logic signed [BEARING_W-1:0] li_val, lp_val;

   assign is_oldest = (entry_ff.age == AGE_W'(HISTORY_DEPTH - 1));
   // clear_in: the oldest sample is at this cell or to the right
   assign clear_out = clear_in && !is_oldest;
   assign entry     = entry_ff;

   // Sorted insert with removal of the oldest sample
   always_comb begin
      // element at this slot once the oldest is dropped
      if (clear_in && !is_oldest) begin
         li     = entry_ff;
         li_inf = 1'b0;
      end else begin
         li     = nxt_entry;
         li_inf = !nxt_exists;
      end
      // element at the slot to the left once the oldest is dropped
      if (!prv_exists) begin
         lp      = entry_ff;
         lp_ninf = 1'b1;
      end else begin
         lp      = clear_in ? prv_entry : entry_ff;
         lp_ninf = 1'b0;
      end
      li_val = li.value;
      lp_val = lp.value;
      li_le  = !li_inf && (li_val <= new_value);
      lp_le  = lp_ninf || (lp_val <= new_value);

      entry_in = entry_ff;
      if (push) begin
         if (li_le) begin
            entry_in.value = li_val;
            entry_in.age   = li.age + AGE_W'(1);
         end else if (lp_le) begin
            entry_in.value = new_value;
            entry_in.age   = '0;
         end else begin
            entry_in.value = lp_val;
            entry_in.age   = lp.age + AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.value <= '0;
         entry_ff.age   <= reset_age;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

[rtl/min_id_source_bearing_median.sv]
// A frame's last entry is inserted into the cell chain; the median of the middle cells
// is then registered as the result. An empty frame's 255 shows in the next cycle.
// Throughput: one source entry per cycle while idle and the result slot is free; a
// frame end also holds off input for the median state after the chain's insert step.
// Reset: synchronous; history reads all zero, frame state restarts, no result pending.
module min_id_source_bearing_median
   import mibm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   mibm_req_if.sink   req_bus,
   mibm_rsp_if.source rsp_bus
);

   state_type state_ff, state_in;

   logic [ID_W-1:0]             lowest_ff, lowest_in;
   logic signed [BEARING_W-1:0] chosen_ff, chosen_in;
   logic                        start_ff, start_in;

   logic                        out_valid_ff, out_valid_in;
   logic signed [BEARING_W-1:0] out_data_ff, out_data_in;

   logic                        accept, push, slot_free;
   logic [ID_W-1:0]             eff_lowest;
   logic signed [BEARING_W-1:0] eff_chosen, new_chosen, median;

   entry_type                   entries [HISTORY_DEPTH];
   logic                        clears  [HISTORY_DEPTH+1];

   assign slot_free     = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && slot_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept && (req_bus.op == OP_SOURCE) && req_bus.last_in_frame;

   // Lowest-id pick within the frame; a later entry wins a tie
   always_comb begin
      eff_lowest = start_ff ? START_ID : lowest_ff;
      eff_chosen = start_ff ? req_bus.bearing : chosen_ff;
      new_chosen = (req_bus.source_id <= eff_lowest) ? req_bus.bearing : eff_chosen;
   end

   // Sorted history chain
   assign clears[0] = 1'b1;
   for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
      mibm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .push       (push),
         .new_value  (new_chosen),
         .prv_entry  (entries[(g == 0) ? 0 : g - 1]),
         .nxt_entry  (entries[(g == HISTORY_DEPTH - 1) ? g : g + 1]),
         .prv_exists (g != 0),
         .nxt_exists (g != HISTORY_DEPTH - 1),
         .clear_in   (clears[g]),
         .reset_age  (AGE_W'(g)),
         .clear_out  (clears[g+1]),
         .entry      (entries[g])
      );
   end

   // Median from the middle cells; even depth averages toward zero
   if ((HISTORY_DEPTH % 2) == 0) begin : g_even
      logic signed [BEARING_W:0] mid_sum, mid_adj;
      always_comb begin
         mid_sum = {entries[MID_LO].value[BEARING_W-1], entries[MID_LO].value}
                 + {entries[MID_HI].value[BEARING_W-1], entries[MID_HI].value};
         mid_adj = mid_sum + {{BEARING_W{1'b0}}, mid_sum[BEARING_W]};
         median  = mid_adj[BEARING_W:1];
      end
   end else begin : g_odd
      assign median = entries[MID_HI].value;
   end

   // Frame state and sequencing
   always_comb begin
      state_in     = state_ff;
      lowest_in    = lowest_ff;
      chosen_in    = chosen_ff;
      start_in     = start_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_data_in  = out_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.op == OP_EMPTY) begin
                  start_in     = 1'b1;
                  out_valid_in = 1'b1;
                  out_data_in  = EMPTY_CODE;
               end else begin
                  lowest_in = (req_bus.source_id <= eff_lowest) ? req_bus.source_id
                                                               : eff_lowest;
                  chosen_in = new_chosen;
                  start_in  = req_bus.last_in_frame;
                  if (req_bus.last_in_frame) begin
                     state_in = ST_MEDIAN;
                  end
               end
            end
         end
         ST_MEDIAN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = median;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lowest_ff    <= START_ID;
         chosen_ff    <= '0;
         start_ff     <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lowest_ff    <= lowest_in;
         chosen_ff    <= chosen_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.smoothed_bearing = out_data_ff;

endmodule

[test/min_id_source_bearing_median_tb.sv]
`timescale 1ns / 100ps
// Testbench for the lowest-id bearing median filter: directed and random frames.
module min_id_source_bearing_median_tb;
   import mibm_pkg::*;

   // one beat of the source channel, plus a flag to let results drain first
   typedef struct {
      logic                        op;
      logic [ID_W-1:0]             source_id;
      logic signed [BEARING_W-1:0] bearing;
      logic                        last_in_frame;
      bit                          drain_first;
   } source_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mibm_req_if req_bus();
   mibm_rsp_if rsp_bus();

   min_id_source_bearing_median i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // beats waiting to be sent, medians waiting to come back
   source_beat_type             beat_q[$];
   logic signed [BEARING_W-1:0] median_q[$];

   // predictor state
   logic signed [BEARING_W-1:0] bearing_log[HISTORY_DEPTH];
   logic [ID_W-1:0]             frame_low_id;
   logic signed [BEARING_W-1:0] frame_bearing;
   bit                          frame_fresh;

   int n_errors    = 0;
   int n_accepted  = 0;
   int n_results   = 0;
   int n_frames    = 0;
   int n_empty     = 0;
   int n_planned   = 0;
   int n_cycles    = 0;
   int gap_left    = 0;
   int gap_pct     = 20;
   int stall_left  = 0;
   int stall_pct   = 20;
   int hold_left   = 0;
   bit long_done   = 0;
   bit tail_phase  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      n_errors++;
   endtask

   function automatic source_beat_type make_entry(input int id, input int brg,
                                                  input int last);
      source_beat_type b;
      b.op            = OP_SOURCE;
      b.source_id     = ID_W'(id);
      b.bearing       = BEARING_W'(brg);
      b.last_in_frame = 1'(last);
      b.drain_first   = 0;
      return b;
   endfunction

   // empty frame; the other fields carry noise
   function automatic source_beat_type make_empty();
      source_beat_type b;
      b.op            = OP_EMPTY;
      b.source_id     = ID_W'($urandom);
      b.bearing       = BEARING_W'($urandom);
      b.last_in_frame = 1'($urandom_range(0, 1));
      b.drain_first   = 0;
      return b;
   endfunction

   // median of the history: sort, middle value or truncated mean of the two middle values
   function automatic logic signed [BEARING_W-1:0] history_median();
      int sorted[HISTORY_DEPTH];
      int v;
      int j;
      int mid;
      for (int i = 0; i < HISTORY_DEPTH; i++)
         sorted[i] = bearing_log[i];
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         v = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > v) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = v;
      end
      if (HISTORY_DEPTH % 2 == 0)
         mid = (sorted[MID_LO] + sorted[MID_HI]) / 2;
      else
         mid = sorted[HISTORY_DEPTH / 2];
      return BEARING_W'(mid);
   endfunction

   // advance the predictor by one accepted beat
   task automatic predict_beat(input logic op, input logic [ID_W-1:0] id,
                               input logic signed [BEARING_W-1:0] brg, input logic last);
      if (op == OP_EMPTY) begin
         frame_fresh = 1;
         median_q.push_back(EMPTY_CODE);
         n_empty++;
      end else begin
         if (frame_fresh) begin
            frame_low_id  = START_ID;
            frame_bearing = brg;
            frame_fresh   = 0;
         end
         // later entry wins a tie
         if (id <= frame_low_id) begin
            frame_low_id  = id;
            frame_bearing = brg;
         end
         if (last) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--)
               bearing_log[i] = bearing_log[i - 1];
            bearing_log[0] = frame_bearing;
            frame_fresh    = 1;
            median_q.push_back(history_median());
            n_frames++;
         end
      end
   endtask

   // driver: predict on acceptance, then present the next beat or idle
   always @(posedge clock) begin
      source_beat_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++)
            bearing_log[i] = '0;
         frame_low_id  = START_ID;
         frame_bearing = '0;
         frame_fresh   = 1;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_beat(req_bus.op, req_bus.source_id, req_bus.bearing, req_bus.last_in_frame);
            n_accepted++;
            if (n_accepted % 80 == 0)
               gap_pct = $urandom_range(0, 3) * 15;
            tail_phase = (n_accepted >= n_planned - 120);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // beat still waiting, leave it on the bus
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (beat_q.size() != 0 &&
                      !(beat_q[0].drain_first && median_q.size() != 0)) begin
            if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
               gap_left = $urandom_range(0, 9);
               req_bus.valid <= 1'b0;
            end else begin
               nxt = beat_q.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.op            <= nxt.op;
               req_bus.source_id     <= nxt.source_id;
               req_bus.bearing       <= nxt.bearing;
               req_bus.last_in_frame <= nxt.last_in_frame;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver ready: random stall bursts, one long hold-off, none near the end
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         n_cycles++;
         if (n_cycles % 150 == 0)
            stall_pct = $urandom_range(0, 3) * 20;
         if (!long_done && n_results >= 120) begin
            hold_left = 400;
            long_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 9);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // monitor: compare each result beat with the oldest expected median
   always @(posedge clock) begin
      logic signed [BEARING_W-1:0] want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (median_q.size() == 0) begin
            report_mismatch($sformatf("result %0d with nothing expected",
                                      rsp_bus.smoothed_bearing));
         end else begin
            want = median_q.pop_front();
            if (rsp_bus.smoothed_bearing !== want)
               report_mismatch($sformatf("result %0d: smoothed_bearing %0d, expected %0d",
                                         n_results, rsp_bus.smoothed_bearing, want));
         end
         n_results++;
      end
   end

   // stimulus and end of run
   initial begin
      int kind;
      int len;
      int brg;
      logic [ID_W-1:0] id;
      logic last;

      req_bus.valid         = 1'b0;
      req_bus.op            = OP_SOURCE;
      req_bus.source_id     = '0;
      req_bus.bearing       = '0;
      req_bus.last_in_frame = 1'b0;
      rsp_bus.ready         = 1'b0;

      // single-entry frames at the bearing extremes
      beat_q.push_back(make_entry(16'h0000, 180, 1));
      beat_q.push_back(make_entry(16'hFFFF, -180, 1));
      // every id above the start value: first entry stays chosen
      beat_q.push_back(make_entry(20000, 10, 0));
      beat_q.push_back(make_entry(30000, 20, 1));
      // equal ids: later entry wins
      beat_q.push_back(make_entry(5, 1, 0));
      beat_q.push_back(make_entry(5, 2, 1));
      // id equal to the start value replaces the default
      beat_q.push_back(make_entry(60000, 3, 0));
      beat_q.push_back(make_entry(10000, 4, 1));
      // empty frames
      beat_q.push_back(make_empty());
      beat_q.push_back(make_empty());
      // empty frame cuts a partial frame
      beat_q.push_back(make_entry(1, 50, 0));
      beat_q.push_back(make_empty());
      beat_q.push_back(make_entry(9000, -5, 1));
      // bearings outside the nominal range, and the one aliasing the empty code
      beat_q.push_back(make_entry(10001, -256, 1));
      beat_q.push_back(make_entry(10000, 255, 1));
      beat_q.push_back(make_entry(7, 200, 0));
      beat_q.push_back(make_entry(8, -200, 0));
      beat_q.push_back(make_entry(6, 97, 1));
      // alternating bit patterns
      beat_q.push_back(make_entry(16'h5555, 9'h155, 0));
      beat_q.push_back(make_entry(16'hAAAA, 9'h0AA, 1));

      // random frames: mostly well formed, some cut short or with noisy last flags
      while (beat_q.size() < 970) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            beat_q.push_back(make_empty());
         end else begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(0, 4))
                  0:       id = ID_W'($urandom_range(0, 15));
                  1:       id = ID_W'($urandom_range(9990, 10010));
                  2:       id = ID_W'($urandom);
                  3:       id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                  default: id = ID_W'($urandom_range(0, 20000));
               endcase
               if ($urandom_range(0, 9) == 0)
                  brg = int'($urandom_range(0, 511)) - 256;
               else
                  brg = int'($urandom_range(0, 360)) - 180;
               last = (kind < 18) ? 1'($urandom_range(0, 1)) : (k == len - 1);
               if (kind < 14 && k == len - 1 && len > 1)
                  beat_q.push_back(make_empty());
               else
                  beat_q.push_back(make_entry(id, brg, last));
            end
         end
      end
      // sender waits for all results twice during the run
      beat_q[350].drain_first = 1;
      beat_q[700].drain_first = 1;
      n_planned = beat_q.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (beat_q.size() != 0 || req_bus.valid || median_q.size() != 0);
      repeat (10) @(posedge clock);

      $display("Sent %0d source beats: %0d complete frames and %0d empty-frame beats,",
               n_accepted, n_frames, n_empty);
      $display("checked %0d median results under random stalls and one long hold-off.",
               n_results);
      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("Verification failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("Timed out with %0d results still expected", median_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule
